// ----- design/mtwa_pkg.sv -----
package mtwa_pkg;

  localparam int TableSlotsDef = 16;
  localparam int ReportMax     = 16;

  localparam int IdW      = 8;
  localparam int LifeW    = 8;
  localparam int SlotOutW = 4;
  localparam int CountW   = 5;

  localparam int ApbDataW = 32;
  localparam int ApbAddrW = 3;

  localparam logic [7:0] OwnIdRst     = 8'd0;
  localparam logic [7:0] AliveTimeRst = 8'd8;

  // paddr[2] selects the register
  localparam logic RegOwnId     = 1'b0;
  localparam logic RegAliveTime = 1'b1;

  typedef enum logic [2:0] {
    OUT_REFRESH = 3'd0,
    OUT_INSERT  = 3'd1,
    OUT_FULL    = 3'd2,
    OUT_IGNORED = 3'd3,
    OUT_REPORT  = 3'd4
  } outcome_e;

  typedef struct packed {
    logic [IdW-1:0]   member;
    logic [LifeW-1:0] life;
  } slot_entry_t;

endpackage

// ----- design/member_table_with_aging_top.sv -----
// Status item: if ignored, the result is registered straight from the response state; else after a scan of all slots.
// Beacon tick: one slot read per cycle from the slot memory, one report per slot up to ReportMax
//   slots; the walk pauses on a report while the output register is stalled.
// Throughput: one item at a time; the next item is taken once the last beat is registered.
// Reset: all slots free at once through per-slot valid bits, member count 0,
//   own_id 0, alive_time 8; no clearing pass.
module member_table_with_aging_top
  import mtwa_pkg::*;
#(
  parameter int TABLE_SLOTS = TableSlotsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                kind_i,
  input  logic [IdW-1:0]      src_id_i,
  input  logic [IdW-1:0]      dst_id_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          outcome_o,
  output logic [SlotOutW-1:0] slot_index_o,
  output logic [IdW-1:0]      member_id_o,
  output logic [CountW-1:0]   member_count_o,
  output logic                last_o
);

  localparam int AW      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int PW      = AW + 1;
  localparam int CW      = $clog2(TABLE_SLOTS + 1);
  localparam int Reports = (TABLE_SLOTS < ReportMax) ? TABLE_SLOTS : ReportMax;
  localparam logic [PW-1:0] SlotsP = PW'(TABLE_SLOTS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_RESP
  } state_e;

  // configuration
  logic [7:0] own_id_q, alive_time_q;
  logic       cfg_wr;
  logic [7:0] life_val;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign life_val = (alive_time_q == 8'd0) ? 8'd1 : alive_time_q;

  always_comb begin
    prdata = '0;
    case (paddr[2])
      RegOwnId:     prdata = ApbDataW'(own_id_q);
      RegAliveTime: prdata = ApbDataW'(alive_time_q);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q     <= OwnIdRst;
      alive_time_q <= AliveTimeRst;
    end else if (cfg_wr) begin
      case (paddr[2])
        RegOwnId:     own_id_q     <= pwdata[7:0];
        RegAliveTime: alive_time_q <= pwdata[7:0];
        default:      ;
      endcase
    end
  end

  // slot memory
  slot_entry_t              mem_q [TABLE_SLOTS];
  slot_entry_t              rd_data_q;
  logic                     rd_vld_q;
  logic [TABLE_SLOTS-1:0]   vld_q;
  logic                     rd_en, wr_en;
  logic [AW-1:0]            rd_addr, wr_addr;
  slot_entry_t              wr_data, rd_entry;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= vld_q[rd_addr];
      end
    end
  end

  assign rd_entry = rd_vld_q ? rd_data_q : '0;

  // control
  state_e          state_q, state_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic            ev_vld_q, ev_vld_d;
  logic [AW-1:0]   ev_idx_q, ev_idx_d;
  logic            kind_q, kind_d;
  logic [IdW-1:0]  src_q, src_d;
  logic            ign_q, ign_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]   before_q, before_d;
  logic            match_q, match_d;
  logic [AW-1:0]   match_idx_q, match_idx_d;
  logic            free_q, free_d;
  logic [AW-1:0]   free_idx_q, free_idx_d;

  logic                out_vld_q, out_vld_d;
  outcome_e            outcome_q, outcome_d;
  logic [SlotOutW-1:0] slot_q, slot_d;
  logic [IdW-1:0]      mid_q, mid_d;
  logic [CountW-1:0]   mcnt_q, mcnt_d;
  logic                last_q, last_d;

  logic        out_free, ev_rep, ev_last, ev_ok, step, room;
  logic [31:0] ev_idx_ext, cnt_ext, before_ext, cnt_inc_ext;
  logic [31:0] match_idx_ext, free_idx_ext;
  slot_entry_t aged;

  assign out_free      = !out_vld_q || !out_stall_i;
  assign ev_idx_ext    = 32'(ev_idx_q);
  assign match_idx_ext = 32'(match_idx_q);
  assign free_idx_ext  = 32'(free_idx_q);
  assign cnt_ext       = 32'(cnt_q);
  assign before_ext    = 32'(before_q);
  assign cnt_inc_ext   = cnt_ext + 32'd1;
  assign ev_rep        = ev_idx_ext < 32'(Reports);
  assign ev_last       = ev_idx_ext == 32'(Reports - 1);
  assign ev_ok         = kind_q ? (!ev_rep || out_free) : 1'b1;
  assign step          = !ev_vld_q || ev_ok;
  assign room          = cnt_ext < 32'(TABLE_SLOTS);
  assign in_stall_o    = state_q != ST_IDLE;

  always_comb begin
    aged = rd_entry;
    if (rd_entry.life != '0) begin
      aged.life = rd_entry.life - LifeW'(1);
      if (aged.life == '0) begin
        aged.member = '0;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    rd_ptr_d    = rd_ptr_q;
    ev_vld_d    = ev_vld_q;
    ev_idx_d    = ev_idx_q;
    kind_d      = kind_q;
    src_d       = src_q;
    ign_d       = ign_q;
    cnt_d       = cnt_q;
    before_d    = before_q;
    match_d     = match_q;
    match_idx_d = match_idx_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    out_vld_d   = out_vld_q && out_stall_i;
    outcome_d   = outcome_q;
    slot_d      = slot_q;
    mid_d       = mid_q;
    mcnt_d      = mcnt_q;
    last_d      = last_q;
    rd_en       = 1'b0;
    rd_addr     = rd_ptr_q[AW-1:0];
    wr_en       = 1'b0;
    wr_addr     = ev_idx_q;
    wr_data     = aged;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          kind_d   = kind_i;
          src_d    = src_id_i;
          ign_d    = (dst_id_i != own_id_q) || (src_id_i == '0);
          before_d = cnt_q;
          rd_ptr_d = '0;
          ev_vld_d = 1'b0;
          match_d  = 1'b0;
          free_d   = 1'b0;
          if (!kind_i && ((dst_id_i != own_id_q) || (src_id_i == '0))) begin
            state_d = ST_RESP;
          end else begin
            state_d = ST_WALK;
          end
        end
      end

      ST_WALK: begin
        if (ev_vld_q && ev_ok) begin
          if (kind_q) begin
            // age the slot and write it back
            wr_en = 1'b1;
            if (rd_entry.life != '0 && aged.life == '0 && cnt_q != '0) begin
              cnt_d = cnt_q - CW'(1);
            end
            if (ev_rep) begin
              out_vld_d = 1'b1;
              outcome_d = OUT_REPORT;
              slot_d    = ev_idx_ext[SlotOutW-1:0];
              mid_d     = (rd_entry.life != '0) ? rd_entry.member : '0;
              mcnt_d    = before_ext[CountW-1:0];
              last_d    = ev_last;
            end
          end else begin
            if (!match_q && rd_entry.member == src_q) begin
              match_d     = 1'b1;
              match_idx_d = ev_idx_q;
            end
            if (!free_q && rd_entry.member == '0) begin
              free_d     = 1'b1;
              free_idx_d = ev_idx_q;
            end
          end
        end
        if (step) begin
          rd_en    = rd_ptr_q < SlotsP;
          ev_vld_d = rd_ptr_q < SlotsP;
          ev_idx_d = rd_ptr_q[AW-1:0];
          if (rd_ptr_q < SlotsP) begin
            rd_ptr_d = rd_ptr_q + PW'(1);
          end
        end
        if (!ev_vld_q && rd_ptr_q == SlotsP) begin
          state_d = kind_q ? ST_IDLE : ST_RESP;
        end
      end

      ST_RESP: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          last_d    = 1'b1;
          slot_d    = '0;
          mid_d     = '0;
          mcnt_d    = cnt_ext[CountW-1:0];
          wr_data.member = src_q;
          wr_data.life   = life_val;
          if (ign_q) begin
            outcome_d = OUT_IGNORED;
          end else if (match_q) begin
            outcome_d = OUT_REFRESH;
            wr_en     = 1'b1;
            wr_addr   = match_idx_q;
            slot_d    = match_idx_ext[SlotOutW-1:0];
            mid_d     = src_q;
          end else if (room && free_q) begin
            outcome_d = OUT_INSERT;
            wr_en     = 1'b1;
            wr_addr   = free_idx_q;
            cnt_d     = cnt_q + CW'(1);
            slot_d    = free_idx_ext[SlotOutW-1:0];
            mid_d     = src_q;
            mcnt_d    = cnt_inc_ext[CountW-1:0];
          end else begin
            outcome_d = OUT_FULL;
          end
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_ptr_q    <= '0;
      ev_vld_q    <= 1'b0;
      ev_idx_q    <= '0;
      kind_q      <= 1'b0;
      src_q       <= '0;
      ign_q       <= 1'b0;
      cnt_q       <= '0;
      before_q    <= '0;
      match_q     <= 1'b0;
      match_idx_q <= '0;
      free_q      <= 1'b0;
      free_idx_q  <= '0;
      out_vld_q   <= 1'b0;
      outcome_q   <= OUT_IGNORED;
      slot_q      <= '0;
      mid_q       <= '0;
      mcnt_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_ptr_q    <= rd_ptr_d;
      ev_vld_q    <= ev_vld_d;
      ev_idx_q    <= ev_idx_d;
      kind_q      <= kind_d;
      src_q       <= src_d;
      ign_q       <= ign_d;
      cnt_q       <= cnt_d;
      before_q    <= before_d;
      match_q     <= match_d;
      match_idx_q <= match_idx_d;
      free_q      <= free_d;
      free_idx_q  <= free_idx_d;
      out_vld_q   <= out_vld_d;
      outcome_q   <= outcome_d;
      slot_q      <= slot_d;
      mid_q       <= mid_d;
      mcnt_q      <= mcnt_d;
      last_q      <= last_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign outcome_o      = outcome_q;
  assign slot_index_o   = slot_q;
  assign member_id_o    = mid_q;
  assign member_count_o = mcnt_q;
  assign last_o         = last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= 32'(TABLE_SLOTS))
    else $error("member count above table size");

  a_idle_no_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !ev_vld_q)
    else $error("slot evaluation pending while accepting items");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write of the same slot in one cycle");

  a_beacon_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && kind_i) |=> (state_q == ST_WALK && rd_ptr_q == '0))
    else $error("beacon tick did not start a slot walk");

  a_report_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && kind_q && ev_vld_q && ev_rep && !out_free) |=> $stable(ev_idx_q))
    else $error("beacon walk advanced past a stalled report");

endmodule
